// ----- hdl/bsr_pkg.sv -----
package bsr_pkg;

   // Default sizes of the brush geometry and the spray mask store.
   localparam int MAX_RADIUS_DEF = 6;
   localparam int MASK_ROWS_DEF  = 14;

   // The span is a fixed 22 columns wide, with bit 0 ten columns left of the centre.
   localparam int MASK_WIDTH  = 22;
   localparam int SPAN_OFFSET = 10;

   // Row counter width: at most fifteen rows per stamp.
   localparam int ROW_W = 4;

   // Spray mask geometry: rows used and the row that sits on the centre.
   localparam int SPRAY0_ROWS   = 12;
   localparam int SPRAY0_CENTER = 5;
   localparam int SPRAY1_ROWS   = 14;
   localparam int SPRAY1_CENTER = 6;

   // Command codes.
   localparam logic CMD_STAMP = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   // Brush kinds.
   localparam logic [1:0] KIND_ROUND  = 2'd0;
   localparam logic [1:0] KIND_SQUARE = 2'd1;
   localparam logic [1:0] KIND_SPRAY  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_CLIP_TOP    = 2'd0;
   localparam logic [1:0] CSR_CLIP_RIGHT  = 2'd1;
   localparam logic [1:0] CSR_CLIP_BOTTOM = 2'd2;

   // Register reset values.
   localparam logic [8:0] CLIP_TOP_RST    = 9'd12;
   localparam logic [9:0] CLIP_RIGHT_RST  = 10'd592;
   localparam logic [8:0] CLIP_BOTTOM_RST = 9'd479;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Canvas clipping box.
   typedef struct packed {
      logic [8:0] top;
      logic [9:0] right;
      logic [8:0] bottom;
   } clip_type;

   // Everything the row unit needs to build one span.
   typedef struct packed {
      logic [1:0]            kind;
      logic [2:0]            size;
      logic signed [4:0]     dy;
      logic [9:0]            center_x;
      logic [9:0]            clip_right;
      logic [MASK_WIDTH-1:0] spray_bits;
   } row_cmd_type;

   // Square of the horizontal offset of span column i from the centre.
   function automatic logic [6:0] dx_square(input int i);
      int d;
      d = i - SPAN_OFFSET;
      return 7'(d * d);
   endfunction

endpackage

// ----- hdl/bsr_mask_store.sv -----
module bsr_mask_store #(
   parameter int MASK_ROWS = bsr_pkg::MASK_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(2*MASK_ROWS)-1:0]  wr_addr,
   input  logic [bsr_pkg::MASK_WIDTH-1:0]  wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(2*MASK_ROWS)-1:0]  rd_addr,
   output logic [bsr_pkg::MASK_WIDTH-1:0]  rd_data
);

   localparam int DEPTH = 2 * MASK_ROWS;

   logic [bsr_pkg::MASK_WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/bsr_row_unit.sv -----
module bsr_row_unit (
   input  bsr_pkg::row_cmd_type            cmd_in,
   output logic [bsr_pkg::MASK_WIDTH-1:0]  mask_out
);

   logic [3:0] dy_abs;
   logic [7:0] dy_sq;
   logic [5:0] size_sq;

   // Terms shared by every column of the row.
   assign dy_abs  = cmd_in.dy[4] ? 4'(-cmd_in.dy) : 4'(cmd_in.dy);
   assign dy_sq   = dy_abs * dy_abs;
   assign size_sq = cmd_in.size * cmd_in.size;

   // Each column is tested against the brush shape and the canvas columns on its own.
   always_comb begin : shape_cols
      logic signed [5:0] dx;
      logic signed [5:0] size_s;
      logic              in_span;
      logic              round_ok;
      logic              shape_bit;
      logic [10:0]       col_sum;
      logic              col_ok;
      size_s = $signed({3'b000, cmd_in.size});
      for (int i = 0; i < bsr_pkg::MASK_WIDTH; i++) begin
         dx        = 6'(i - bsr_pkg::SPAN_OFFSET);
         in_span   = (dx >= -size_s) && (dx <= size_s);
         round_ok  = ({2'b00, bsr_pkg::dx_square(i)} + {1'b0, dy_sq}) <= {3'b000, size_sq};
         col_sum   = 11'(cmd_in.center_x) + 11'(i);
         col_ok    = (col_sum >= 11'(bsr_pkg::SPAN_OFFSET)) &&
                     (col_sum < (11'(cmd_in.clip_right) + 11'(bsr_pkg::SPAN_OFFSET)));
         case (cmd_in.kind)
            bsr_pkg::KIND_ROUND:  shape_bit = in_span && round_ok;
            bsr_pkg::KIND_SQUARE: shape_bit = in_span;
            bsr_pkg::KIND_SPRAY:  shape_bit = cmd_in.spray_bits[i];
            default:              shape_bit = 1'b0;
         endcase
         mask_out[i] = shape_bit && col_ok;
      end
   end

endmodule

// ----- hdl/bsr_sequencer.sv -----
module bsr_sequencer #(
   parameter int MAX_RADIUS = bsr_pkg::MAX_RADIUS_DEF,
   parameter int MASK_ROWS  = bsr_pkg::MASK_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [9:0]                      req_center_x,
   input  logic [8:0]                      req_center_y,
   input  logic [1:0]                      req_brush_kind,
   input  logic [2:0]                      req_brush_size,
   input  logic [7:0]                      req_paint_color,
   input  bsr_pkg::clip_type               clip_in,
   output logic                            rd_en,
   output logic [$clog2(2*MASK_ROWS)-1:0]  rd_addr,
   input  logic [bsr_pkg::MASK_WIDTH-1:0]  spray_bits_in,
   output bsr_pkg::row_cmd_type            row_cmd,
   input  logic [bsr_pkg::MASK_WIDTH-1:0]  row_mask_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [8:0]                      rsp_row,
   output logic signed [10:0]              rsp_first_column,
   output logic [bsr_pkg::MASK_WIDTH-1:0]  rsp_pixel_mask,
   output logic [7:0]                      rsp_color,
   output logic                            rsp_last
);

   localparam int ADDR_W      = $clog2(2 * MASK_ROWS);
   localparam int SPRAY1_USED = (bsr_pkg::SPRAY1_ROWS > MASK_ROWS) ?
                                MASK_ROWS : bsr_pkg::SPRAY1_ROWS;
   localparam logic [bsr_pkg::ROW_W-1:0] SPRAY0_LAST = bsr_pkg::ROW_W'(bsr_pkg::SPRAY0_ROWS - 1);
   localparam logic [bsr_pkg::ROW_W-1:0] SPRAY1_LAST = bsr_pkg::ROW_W'(SPRAY1_USED - 1);

   bsr_pkg::state_type state_ff, state_in;

   logic [bsr_pkg::ROW_W-1:0] r_ff, r_in;
   logic [bsr_pkg::ROW_W-1:0] last_r_ff;
   logic [1:0]                kind_ff;
   logic [2:0]                size_ff;
   logic                      sel_ff;
   logic [9:0]                cx_ff;
   logic signed [10:0]        base_ff;
   logic [7:0]                color_ff;

   logic                      b_valid_ff, b_valid_in;
   logic [bsr_pkg::ROW_W-1:0] b_r_ff;

   logic                      out_valid_ff, out_valid_in;
   logic [8:0]                out_row_ff;
   logic signed [10:0]        out_first_ff;
   logic [bsr_pkg::MASK_WIDTH-1:0] out_mask_ff;
   logic [7:0]                out_color_ff;
   logic                      out_last_ff;

   logic                      accept;
   logic                      start;
   logic                      issue;
   logic                      out_free;
   logic                      in_box;
   logic                      b_move;
   logic                      b_emit;
   logic                      b_last;
   logic signed [10:0]        row_now;
   logic [2:0]                size_sat;
   logic                      start_sel;
   logic [bsr_pkg::ROW_W-1:0] start_last;
   logic signed [10:0]        start_base;

   // Handshake decode.
   assign accept = req_valid && !req_stall;
   assign start  = accept && (req_command == bsr_pkg::CMD_STAMP) &&
                   (req_brush_kind != bsr_pkg::KIND_NONE);

   // Stamp set-up: saturated radius, row count and the canvas row of row zero.
   always_comb begin
      size_sat  = (int'(req_brush_size) > MAX_RADIUS) ? 3'(MAX_RADIUS) : req_brush_size;
      start_sel = req_brush_size[0];
      if (req_brush_kind == bsr_pkg::KIND_SPRAY) begin
         start_last = start_sel ? SPRAY1_LAST : SPRAY0_LAST;
         start_base = $signed({2'b00, req_center_y}) -
                      (start_sel ? 11'sd6 : 11'sd5);
      end else begin
         start_last = {size_sat, 1'b0};
         start_base = $signed({2'b00, req_center_y}) - $signed({8'd0, size_sat});
      end
   end

   // Row held in the compute stage and its place in the clipping box.
   assign row_now  = base_ff + $signed({7'd0, b_r_ff});
   assign in_box   = (row_now >= $signed({2'b00, clip_in.top})) &&
                     (row_now <= $signed({2'b00, clip_in.bottom}));
   assign b_last   = (b_r_ff == last_r_ff) || (row_now == $signed({2'b00, clip_in.bottom}));
   assign out_free = !out_valid_ff || !rsp_stall;
   assign b_move   = b_valid_ff && (!in_box || out_free);
   assign b_emit   = b_valid_ff && in_box && out_free;

   // Command to the shared row unit.
   always_comb begin
      row_cmd.kind       = kind_ff;
      row_cmd.size       = size_ff;
      row_cmd.dy         = $signed({1'b0, b_r_ff}) - $signed({2'b00, size_ff});
      row_cmd.center_x   = cx_ff;
      row_cmd.clip_right = clip_in.right;
      row_cmd.spray_bits = spray_bits_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsr_pkg::ST_IDLE: begin
            if (start) begin
               state_in = bsr_pkg::ST_RUN;
            end
         end
         bsr_pkg::ST_RUN: begin
            if (issue && (r_ff == last_r_ff)) begin
               state_in = bsr_pkg::ST_DRAIN;
            end
         end
         bsr_pkg::ST_DRAIN: begin
            if (!b_valid_ff || b_move) begin
               state_in = bsr_pkg::ST_IDLE;
            end
         end
         default: state_in = bsr_pkg::ST_IDLE;
      endcase
   end

   // State outputs: the input closes while a stamp is busy, rows issue one a cycle unless the compute stage is held.
   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      case (state_ff)
         bsr_pkg::ST_IDLE:  req_stall = 1'b0;
         bsr_pkg::ST_RUN:   issue     = !b_valid_ff || b_move;
         bsr_pkg::ST_DRAIN: issue     = 1'b0;
         default:           req_stall = 1'b1;
      endcase
   end

   // Store read runs alongside the issue of a row.
   assign rd_en   = issue;
   assign rd_addr = sel_ff ? (ADDR_W'(MASK_ROWS) + ADDR_W'(r_ff)) : ADDR_W'(r_ff);

   // Control next values.
   assign r_in         = start ? '0 : (issue ? r_ff + 1'b1 : r_ff);
   assign b_valid_in   = issue ? 1'b1 : (b_move ? 1'b0 : b_valid_ff);
   assign out_valid_in = b_emit ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsr_pkg::ST_IDLE;
         r_ff         <= '0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         r_ff         <= r_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Stamp context, captured on the accepted beat.
   always_ff @(posedge clock) begin
      if (start) begin
         last_r_ff <= start_last;
         kind_ff   <= req_brush_kind;
         size_ff   <= size_sat;
         sel_ff    <= start_sel;
         cx_ff     <= req_center_x;
         base_ff   <= start_base;
         color_ff  <= req_paint_color;
      end
   end

   // Compute stage row index.
   always_ff @(posedge clock) begin
      if (issue) begin
         b_r_ff <= r_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (b_emit) begin
         out_row_ff   <= row_now[8:0];
         out_first_ff <= $signed({1'b0, cx_ff}) - 11'sd10;
         out_mask_ff  <= row_mask_in;
         out_color_ff <= color_ff;
         out_last_ff  <= b_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_row          = out_row_ff;
   assign rsp_first_column = out_first_ff;
   assign rsp_pixel_mask   = out_mask_ff;
   assign rsp_color        = out_color_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ----- hdl/brush_stamp_rasterizer.sv -----
// Channel  Handshake          Beat carries
// req      req_valid/stall    command, centre, brush kind and size, colour, mask load
// rsp      rsp_valid/stall    one clipped row span with colour and last flag
// csr      csr_valid/ready    register index and data for the clipping box
//
// A mask load or an empty stamp leaves req_stall low. A stamp keeps req_stall high
// while it issues its rows and drains the compute stage, one row a cycle through the
// shared row unit when rsp_stall does not hold the output register. The spray store
// has a registered read. Reset is synchronous, clears the control state and returns
// the clipping box to its reset values; the spray store holds no reset value. The
// output register takes a new span only when empty or while its span is being taken.
module brush_stamp_rasterizer #(
   parameter int MAX_RADIUS = bsr_pkg::MAX_RADIUS_DEF,
   parameter int MASK_ROWS  = bsr_pkg::MASK_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [9:0]                      req_center_x,
   input  logic [8:0]                      req_center_y,
   input  logic [1:0]                      req_brush_kind,
   input  logic [2:0]                      req_brush_size,
   input  logic [7:0]                      req_paint_color,
   input  logic                            req_mask_select,
   input  logic [3:0]                      req_mask_row,
   input  logic [bsr_pkg::MASK_WIDTH-1:0]  req_mask_bits,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [8:0]                      rsp_row,
   output logic signed [10:0]              rsp_first_column,
   output logic [bsr_pkg::MASK_WIDTH-1:0]  rsp_pixel_mask,
   output logic [7:0]                      rsp_color,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [9:0]                      csr_data
);

   localparam int ADDR_W = $clog2(2 * MASK_ROWS);

   bsr_pkg::clip_type    clip;
   bsr_pkg::row_cmd_type row_cmd;

   logic [8:0]                     clip_top_ff;
   logic [9:0]                     clip_right_ff;
   logic [8:0]                     clip_bottom_ff;
   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic                           rd_en;
   logic [ADDR_W-1:0]              rd_addr;
   logic [bsr_pkg::MASK_WIDTH-1:0] rd_data;
   logic [bsr_pkg::MASK_WIDTH-1:0] row_mask;

   // Configuration registers; every beat is taken at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_top_ff    <= bsr_pkg::CLIP_TOP_RST;
         clip_right_ff  <= bsr_pkg::CLIP_RIGHT_RST;
         clip_bottom_ff <= bsr_pkg::CLIP_BOTTOM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bsr_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr_data[8:0];
            bsr_pkg::CSR_CLIP_RIGHT:  clip_right_ff  <= csr_data;
            bsr_pkg::CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign clip.top    = clip_top_ff;
   assign clip.right  = clip_right_ff;
   assign clip.bottom = clip_bottom_ff;

   // A mask load writes one store row; rows beyond the store are dropped.
   assign wr_en   = req_valid && !req_stall && (req_command == bsr_pkg::CMD_LOAD) &&
                    (int'(req_mask_row) < MASK_ROWS);
   assign wr_addr = req_mask_select ? (ADDR_W'(MASK_ROWS) + ADDR_W'(req_mask_row))
                                    : ADDR_W'(req_mask_row);

   bsr_mask_store #(
      .MASK_ROWS (MASK_ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_mask_bits),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bsr_row_unit u_row (
      .cmd_in   (row_cmd),
      .mask_out (row_mask)
   );

   bsr_sequencer #(
      .MAX_RADIUS (MAX_RADIUS),
      .MASK_ROWS  (MASK_ROWS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_brush_kind   (req_brush_kind),
      .req_brush_size   (req_brush_size),
      .req_paint_color  (req_paint_color),
      .clip_in          (clip),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .spray_bits_in    (rd_data),
      .row_cmd          (row_cmd),
      .row_mask_in      (row_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_first_column (rsp_first_column),
      .rsp_pixel_mask   (rsp_pixel_mask),
      .rsp_color        (rsp_color),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- hdl/bsr_checker.sv -----
module bsr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_command,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [8:0]                      rsp_row,
   input logic [bsr_pkg::MASK_WIDTH-1:0]  rsp_pixel_mask,
   input logic                            rsp_last
);

   // Coming out of reset the input is open and no span is shown.
   a_reset_clean: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_stall && !rsp_valid))
      else $error("block not clean after reset");

   // A span waiting on the output holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_row) && $stable(rsp_pixel_mask) && $stable(rsp_last)))
      else $error("stalled span changed");

   // A mask load leaves the input open on the next cycle.
   a_load_short: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_command == bsr_pkg::CMD_LOAD)) |=> !req_stall)
      else $error("mask load kept the input stalled");

   // While a stamp still owes spans, no new request is taken.
   a_stamp_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request taken before the stamp finished");

endmodule

bind brush_stamp_rasterizer bsr_checker u_bsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_row        (rsp_row),
   .rsp_pixel_mask (rsp_pixel_mask),
   .rsp_last       (rsp_last)
);

// ----- dv/tb_brush_stamp_rasterizer.sv -----
module tb_brush_stamp_rasterizer;

   localparam int MAX_RADIUS   = bsr_pkg::MAX_RADIUS_DEF;
   localparam int MASK_ROWS    = bsr_pkg::MASK_ROWS_DEF;
   localparam int MASK_WIDTH   = bsr_pkg::MASK_WIDTH;
   localparam int SPAN_OFFSET  = bsr_pkg::SPAN_OFFSET;
   localparam int DRAIN_CYCLES = 24;
   localparam int RUN_LIMIT    = 400000;

   // One request beat, field for field as the ports carry it.
   typedef struct packed {
      logic                  command;
      logic [9:0]            center_x;
      logic [8:0]            center_y;
      logic [1:0]            brush_kind;
      logic [2:0]            brush_size;
      logic [7:0]            paint_color;
      logic                  mask_select;
      logic [3:0]            mask_row;
      logic [MASK_WIDTH-1:0] mask_bits;
   } brush_req_type;

   // One row span as the result channel carries it.
   typedef struct packed {
      logic [8:0]            row;
      logic [10:0]           first_column;
      logic [MASK_WIDTH-1:0] pixel_mask;
      logic [7:0]            color;
      logic                  last;
   } row_span_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   brush_req_type         req_beat = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [8:0]            rsp_row;
   logic signed [10:0]    rsp_first_column;
   logic [MASK_WIDTH-1:0] rsp_pixel_mask;
   logic [7:0]            rsp_color;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = bsr_pkg::CSR_CLIP_TOP;
   logic [9:0]            csr_data = '0;

   // Local copy of the clipping box and of the spray mask store.
   int                    box_top = bsr_pkg::CLIP_TOP_RST;
   int                    box_right = bsr_pkg::CLIP_RIGHT_RST;
   int                    box_bottom = bsr_pkg::CLIP_BOTTOM_RST;
   logic [MASK_WIDTH-1:0] spray_words [0:2*MASK_ROWS-1];

   brush_req_type         pending_beats [$];
   row_span_type          expected_spans [$];
   row_span_type          oldest_span;
   int                    send_idle_pct = 31;
   int                    recv_stall_pct = 78;
   int                    mismatch_count = 0;
   int                    stamp_count = 0;
   int                    load_count = 0;
   int                    span_count = 0;
   int                    clip_settings = 1;

   brush_stamp_rasterizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_beat.command),
      .req_center_x     (req_beat.center_x),
      .req_center_y     (req_beat.center_y),
      .req_brush_kind   (req_beat.brush_kind),
      .req_brush_size   (req_beat.brush_size),
      .req_paint_color  (req_beat.paint_color),
      .req_mask_select  (req_beat.mask_select),
      .req_mask_row     (req_beat.mask_row),
      .req_mask_bits    (req_beat.mask_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_first_column (rsp_first_column),
      .rsp_pixel_mask   (rsp_pixel_mask),
      .rsp_color        (rsp_color),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Turns one accepted beat into the row spans it should produce, or updates the
   // spray store for a mask load.
   function automatic void rasterize_beat(input brush_req_type b);
      row_span_type          spans [$];
      row_span_type          s;
      logic [MASK_WIDTH-1:0] window;
      logic [MASK_WIDTH-1:0] shape;
      int                    cx;
      int                    cy;
      int                    size;
      int                    sel;
      int                    first_dy;
      int                    last_dy;
      int                    dx;
      int                    col;
      int                    row;
      if (b.command == bsr_pkg::CMD_LOAD) begin
         if (int'(b.mask_row) < MASK_ROWS) begin
            spray_words[int'(b.mask_select) * MASK_ROWS + int'(b.mask_row)] = b.mask_bits;
         end
         return;
      end
      if (b.brush_kind == bsr_pkg::KIND_NONE) return;
      cx = int'(b.center_x);
      cy = int'(b.center_y);
      sel = int'(b.brush_size[0]);
      size = (int'(b.brush_size) > MAX_RADIUS) ? MAX_RADIUS : int'(b.brush_size);

      // Columns that lie on the canvas, left of the right clip edge.
      window = '0;
      for (int i = 0; i < MASK_WIDTH; i++) begin
         col = cx - SPAN_OFFSET + i;
         if (col >= 0 && col < box_right) window[i] = 1'b1;
      end

      if (b.brush_kind == bsr_pkg::KIND_SPRAY) begin
         first_dy = sel ? -bsr_pkg::SPRAY1_CENTER : -bsr_pkg::SPRAY0_CENTER;
         last_dy  = sel ? bsr_pkg::SPRAY1_ROWS - 1 - bsr_pkg::SPRAY1_CENTER
                        : bsr_pkg::SPRAY0_ROWS - 1 - bsr_pkg::SPRAY0_CENTER;
      end else begin
         first_dy = -size;
         last_dy  = size;
      end

      for (int dy = first_dy; dy <= last_dy; dy++) begin
         row = cy + dy;
         if (b.brush_kind == bsr_pkg::KIND_SPRAY) begin
            shape = spray_words[sel * MASK_ROWS + dy - first_dy];
         end else begin
            shape = '0;
            for (int i = 0; i < MASK_WIDTH; i++) begin
               dx = i - SPAN_OFFSET;
               if (dx >= -size && dx <= size &&
                   (b.brush_kind == bsr_pkg::KIND_SQUARE ||
                    dx * dx + dy * dy <= size * size))
                  shape[i] = 1'b1;
            end
         end
         // Rows outside the box are dropped; rows inside go out even when empty.
         if (row >= box_top && row <= box_bottom) begin
            s.row          = 9'(row);
            s.first_column = 11'(cx - SPAN_OFFSET);
            s.pixel_mask   = shape & window;
            s.color        = b.paint_color;
            s.last         = 1'b0;
            spans.push_back(s);
         end
      end

      if (spans.size() != 0) begin
         s = spans.pop_back();
         s.last = 1'b1;
         spans.push_back(s);
      end
      foreach (spans[k]) expected_spans.push_back(spans[k]);
   endfunction

   function automatic brush_req_type stamp_beat(input logic [1:0] kind, input int size,
                                                input int x, input int y, input int color);
      brush_req_type b;
      b.command     = bsr_pkg::CMD_STAMP;
      b.center_x    = 10'(x);
      b.center_y    = 9'(y);
      b.brush_kind  = kind;
      b.brush_size  = 3'(size);
      b.paint_color = 8'(color);
      // Fields that a stamp ignores carry noise.
      b.mask_select = 1'($urandom);
      b.mask_row    = 4'($urandom);
      b.mask_bits   = MASK_WIDTH'($urandom);
      return b;
   endfunction

   function automatic brush_req_type load_beat(input int sel, input int row,
                                               input logic [MASK_WIDTH-1:0] bits);
      brush_req_type b;
      b = stamp_beat(2'($urandom), $urandom_range(7), $urandom_range(639),
                     $urandom_range(479), $urandom_range(255));
      b.command     = bsr_pkg::CMD_LOAD;
      b.mask_select = 1'(sel);
      b.mask_row    = 4'(row);
      b.mask_bits   = bits;
      return b;
   endfunction

   // Mostly well-formed stamps near the canvas edges, with loads and odd kinds mixed in.
   function automatic brush_req_type random_beat();
      int       pick;
      int       x;
      int       y;
      int       size;
      logic [1:0] kind;
      pick = $urandom_range(99);
      if (pick < 10) return load_beat($urandom_range(1), $urandom_range(15), MASK_WIDTH'($urandom));
      case ($urandom_range(3))
         0: x = $urandom_range(15);
         1: x = $urandom_range(639, 580);
         default: x = $urandom_range(639);
      endcase
      case ($urandom_range(3))
         0: y = $urandom_range(20);
         1: y = $urandom_range(479, 460);
         default: y = $urandom_range(479);
      endcase
      if (pick < 15) begin
         kind = bsr_pkg::KIND_NONE;
      end else begin
         kind = 2'($urandom_range(2));
      end
      if (kind == bsr_pkg::KIND_SPRAY || $urandom_range(7) == 0) begin
         size = $urandom_range(7);
      end else begin
         size = $urandom_range(MAX_RADIUS);
      end
      return stamp_beat(kind, size, x, y, $urandom_range(255));
   endfunction

   task automatic write_clip(input logic [1:0] index, input int value);
      csr_index <= index;
      csr_data  <= 10'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         bsr_pkg::CSR_CLIP_TOP:    box_top = value;
         bsr_pkg::CSR_CLIP_RIGHT:  box_right = value;
         bsr_pkg::CSR_CLIP_BOTTOM: box_bottom = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_canvas(input int top, input int right, input int bottom);
      write_clip(bsr_pkg::CSR_CLIP_TOP, top);
      write_clip(bsr_pkg::CSR_CLIP_RIGHT, right);
      write_clip(bsr_pkg::CSR_CLIP_BOTTOM, bottom);
      clip_settings++;
   endtask

   // Waits until every beat is accepted and every span has come back, then lets a
   // trailing stamp with no spans finish before anything else happens.
   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_valid || expected_spans.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) pending_beats.push_back(random_beat());
      wait_drained();
   endtask

   // Driver: predicts each accepted beat and presents the next one, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_beat.command == bsr_pkg::CMD_LOAD) load_count++;
            else stamp_count++;
            rasterize_beat(req_beat);
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_beat  <= pending_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every accepted span against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_spans.size() == 0) begin
               report_mismatch($sformatf("unexpected span at row %0d", rsp_row));
            end else begin
               oldest_span = expected_spans.pop_front();
               span_count++;
               if (rsp_row !== oldest_span.row)
                  report_mismatch($sformatf("row %0d, wanted %0d", rsp_row, oldest_span.row));
               if (rsp_first_column !== oldest_span.first_column)
                  report_mismatch($sformatf("first_column %0d, wanted %0d at row %0d",
                                            rsp_first_column,
                                            $signed(oldest_span.first_column),
                                            oldest_span.row));
               if (rsp_pixel_mask !== oldest_span.pixel_mask)
                  report_mismatch($sformatf("pixel_mask %06h, wanted %06h at row %0d",
                                            rsp_pixel_mask, oldest_span.pixel_mask,
                                            oldest_span.row));
               if (rsp_color !== oldest_span.color)
                  report_mismatch($sformatf("color %0d, wanted %0d at row %0d",
                                            rsp_color, oldest_span.color, oldest_span.row));
               if (rsp_last !== oldest_span.last)
                  report_mismatch($sformatf("last %b, wanted %b at row %0d",
                                            rsp_last, oldest_span.last, oldest_span.row));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      int top;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill both spray masks completely so that no stamp reads an unwritten word.
      for (int sel = 0; sel < 2; sel++) begin
         for (int r = 0; r < MASK_ROWS; r++) begin
            case (r)
               0: pending_beats.push_back(load_beat(sel, r, '1));
               1: pending_beats.push_back(load_beat(sel, r, '0));
               2: pending_beats.push_back(load_beat(sel, r, 22'h155555));
               default: pending_beats.push_back(load_beat(sel, r, MASK_WIDTH'($urandom)));
            endcase
         end
      end
      // Loads past the last mask row are ignored.
      pending_beats.push_back(load_beat(0, 15, '1));
      pending_beats.push_back(load_beat(1, 14, '1));

      // Directed stamps under the reset clipping box.
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_ROUND, 0, 320, 240, 1));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_ROUND, 3, 591, 100, 255));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_ROUND, 6, 100, 200, 0));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_ROUND, 7, 200, 300, 7));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SQUARE, 0, 50, 50, 128));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SQUARE, 6, 639, 479, 3));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SQUARE, 7, 5, 12, 200));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SQUARE, 2, 10, 479, 9));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SPRAY, 0, 320, 240, 17));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SPRAY, 1, 9, 13, 34));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SPRAY, 6, 630, 475, 51));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SPRAY, 7, 400, 100, 68));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_NONE, 3, 320, 240, 85));
      // Every row lies above the top clip edge, so this stamp yields nothing.
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_ROUND, 6, 0, 0, 102));
      pending_beats.push_back(load_beat(1, 6, '1));
      pending_beats.push_back(stamp_beat(bsr_pkg::KIND_SPRAY, 1, 320, 240, 119));
      wait_drained();

      // Full canvas.
      set_canvas(0, 640, 479);
      run_random(30);

      // Inverted box lets no row through.
      set_canvas(300, 1, 200);
      run_random(8);

      // A single row at the bottom and a single paintable column.
      set_canvas(479, 1, 479);
      run_random(10);

      // Random box, with the idling of the two sides swapped.
      send_idle_pct  = 78;
      recv_stall_pct = 31;
      top = $urandom_range(479);
      set_canvas(top, $urandom_range(640, 1), $urandom_range(479, top));
      run_random(30);

      // Another random box at full rate.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      top = $urandom_range(479);
      set_canvas(top, $urandom_range(640, 1), $urandom_range(479, top));
      run_random(30);

      if (expected_spans.size() != 0)
         report_mismatch($sformatf("%0d spans never arrived", expected_spans.size()));
      $display("Run covered %0d stamps and %0d mask loads over %0d clipping boxes,",
               stamp_count, load_count, clip_settings);
      $display("comparing %0d row spans with %0d mismatches.", span_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(RUN_LIMIT);
      $display("Timeout: the run did not drain in time.");
      $display("Some tests failed");
      $finish;
   end

endmodule
